// ===== hdl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Standalone package with no dependencies; tcw_engine and text_console_writer use it.
`default_nettype none

package tcw_pkg;

  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef logic [CHAR_W-1:0]    char_t;
  typedef logic [ATTR_W-1:0]    attr_t;
  typedef logic [CELL_W-1:0]    cell_idx_t;
  typedef logic [COL_OUT_W-1:0] col_out_t;
  typedef logic [ROW_OUT_W-1:0] row_out_t;

  // One finished result as it leaves the engine.
  typedef struct packed {
    logic     scrolled;
    row_out_t row;
    col_out_t column;
    attr_t    cell_attr;
    char_t    cell_char;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/tcw_screen_ram.sv =====
// Screen cell store: one write port and one read port with registered read data.
// Depends on nothing but its parameters; instantiated by text_console_writer.
`default_nettype none

module tcw_screen_ram #(
  parameter int DEPTH  = 2000,
  parameter int DATA_W = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_engine.sv =====
// Console sequencer: clearing pass, cursor, character writes, reads and scroll copy.
// Uses tcw_pkg; drives the ports of tcw_screen_ram from text_console_writer.
`default_nettype none

module tcw_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire logic              in_action,
  input  wire tcw_pkg::char_t    in_char,
  input  wire tcw_pkg::cell_idx_t in_cell,
  input  wire tcw_pkg::attr_t    attr,
  output      logic              res_valid,
  input  wire logic              res_ready,
  output      tcw_pkg::result_t  res,
  output      logic              ram_wr_en,
  output      logic [AW-1:0]     ram_wr_addr,
  output      logic [15:0]       ram_wr_data,
  output      logic [AW-1:0]     ram_rd_addr,
  input  wire logic [15:0]       ram_rd_data
);

  localparam int CW   = $clog2(COLUMNS);
  localparam int RW   = $clog2(ROWS + 1);
  localparam int MOVE = (ROWS - 1) * COLUMNS;

  typedef logic [AW-1:0] addr_t;
  typedef logic [CW-1:0] col_t;
  typedef logic [RW-1:0] row_t;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  logic [2:0]      state_r, state_nxt;
  col_t            col_r, col_nxt;
  row_t            row_r, row_nxt;
  addr_t           cnt_r, cnt_nxt;
  logic            wb_v_r, wb_v_nxt;
  addr_t           wb_addr_r, wb_addr_nxt;
  logic            wb_zero_r, wb_zero_nxt;
  logic            scrolled_r, scrolled_nxt;
  tcw_pkg::char_t  char_r, char_nxt;
  tcw_pkg::char_t  rd_char_r, rd_char_nxt;
  tcw_pkg::attr_t  rd_attr_r, rd_attr_nxt;
  addr_t           put_pos;

  assign put_pos = addr_t'(addr_t'(row_r) * addr_t'(COLUMNS) + addr_t'(col_r));

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    cnt_nxt      = cnt_r;
    wb_v_nxt     = 1'b0;
    wb_addr_nxt  = wb_addr_r;
    wb_zero_nxt  = wb_zero_r;
    scrolled_nxt = scrolled_r;
    char_nxt     = char_r;
    rd_char_nxt  = rd_char_r;
    rd_attr_nxt  = rd_attr_r;

    unique case (state_r)
      S_CLEAR: begin
        cnt_nxt = addr_t'(cnt_r + 1'b1);
        if (cnt_r == addr_t'(CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          scrolled_nxt = 1'b0;
          rd_char_nxt  = '0;
          rd_attr_nxt  = '0;
          char_nxt     = in_char;
          if (in_action == tcw_pkg::ACT_READ) begin
            // The read was launched this cycle from the input index.
            state_nxt = (32'(in_cell) < 32'(CELLS)) ? S_RDWAIT : S_RESP;
          end else if (in_char == tcw_pkg::NEWLINE_CODE) begin
            col_nxt = '0;
            if (row_r < row_t'(ROWS)) begin
              row_nxt = row_t'(row_r + 1'b1);
            end
            state_nxt = S_RESP;
          end else if (row_r >= row_t'(ROWS)) begin
            scrolled_nxt = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_SCROLL;
          end else begin
            state_nxt = S_PUT;
          end
        end
      end
      S_RDWAIT: begin
        rd_char_nxt = ram_rd_data[7:0];
        rd_attr_nxt = ram_rd_data[15:8];
        state_nxt   = S_RESP;
      end
      S_SCROLL: begin
        // Cell cnt is read one row down now and written back next cycle;
        // the last row gets zeros through the same write-back slot.
        wb_v_nxt    = 1'b1;
        wb_addr_nxt = cnt_r;
        wb_zero_nxt = (32'(cnt_r) >= 32'(MOVE));
        cnt_nxt     = addr_t'(cnt_r + 1'b1);
        if (cnt_r == addr_t'(CELLS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        col_nxt   = '0;
        row_nxt   = row_t'(ROWS - 1);
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (col_r == col_t'(COLUMNS - 1)) begin
          col_nxt = '0;
          row_nxt = row_t'(row_r + 1'b1);
        end else begin
          col_nxt = col_t'(col_r + 1'b1);
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Write port: scroll write-back first, then the clearing pass, then a put.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = put_pos;
    ram_wr_data = {attr, char_r};
    if (wb_v_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wb_addr_r;
      ram_wr_data = wb_zero_r ? 16'h0000 : ram_rd_data;
    end else if (state_r == S_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cnt_r;
      ram_wr_data = 16'h0000;
    end else if (state_r == S_PUT) begin
      ram_wr_en = 1'b1;
    end
  end

  assign ram_rd_addr = (state_r == S_SCROLL) ? addr_t'(cnt_r + addr_t'(COLUMNS))
                                             : addr_t'(in_cell);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      col_r      <= '0;
      row_r      <= '0;
      cnt_r      <= '0;
      wb_v_r     <= 1'b0;
      scrolled_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      cnt_r      <= cnt_nxt;
      wb_v_r     <= wb_v_nxt;
      scrolled_r <= scrolled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= wb_addr_nxt;
    wb_zero_r <= wb_zero_nxt;
    char_r    <= char_nxt;
    rd_char_r <= rd_char_nxt;
    rd_attr_r <= rd_attr_nxt;
  end

  assign in_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_RESP);
  assign res.scrolled  = scrolled_r;
  assign res.row       = tcw_pkg::row_out_t'(row_r);
  assign res.column    = tcw_pkg::col_out_t'(col_r);
  assign res.cell_attr = rd_attr_r;
  assign res.cell_char = rd_char_r;

endmodule

`default_nettype wire

// ===== hdl/text_console_writer.sv =====
// Text console writer: one item is in work at a time, so a new beat is taken only once
// the engine has handed the previous result over to the output register.
// A put at a pending scroll first copies the screen memory one row up, cell by cell,
// through the single read and write port of the screen memory.
// After reset (synchronous, rst_n low) a clearing pass writes zero to all COLUMNS*ROWS
// cells, one per cycle, and in_tready stays low for its length; config writes still land.
`default_nettype none

module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration: attribute byte stored with every written character.
  input  wire logic                               cfg_wr_en,
  input  wire logic [tcw_pkg::ATTR_W-1:0]         cfg_wr_data,
  // Input beats.
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  input  wire logic [tcw_pkg::IN_TDATA_W-1:0]     in_tdata,  // char_code[7:0], cell_index[18:8]
  input  wire logic [0:0]                         in_tuser,  // action[0]
  // Result beats.
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // cell_char[7:0], cell_attr[15:8], column_now[22:16], row_now[27:23], did_scroll[28]
  output      logic [tcw_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // The user must write the attribute register only while the console is idle; the block does not enforce this.
  tcw_pkg::attr_t attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tcw_pkg::ATTR_RESET;
    end else if (cfg_wr_en) begin
      attr_r <= cfg_wr_data;
    end
  end

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [15:0]      ram_wr_data;
  logic [AW-1:0]    ram_rd_addr;
  logic [15:0]      ram_rd_data;

  logic             res_valid;
  logic             res_ready;
  tcw_pkg::result_t res;

  // The screen memory holds one 16-bit cell per character position, character
  // in the low byte and attribute in the high byte.
  tcw_screen_ram #(
    .DEPTH  (CELLS),
    .DATA_W (16)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // The engine owns the cursor and sequences every memory access: the
  // clearing pass, single-cell reads, character writes and the scroll, which
  // copies each cell one row up through a one-deep write-back slot.
  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_action   (in_tuser[0]),
    .in_char     (in_tdata[7:0]),
    .in_cell     (in_tdata[18:8]),
    .attr        (attr_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Output register: the engine hands its result over and goes back to idle,
  // so the next beat can be taken while this one waits for the sink.
  logic             out_valid_r, out_valid_nxt;
  tcw_pkg::result_t out_res_r;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.scrolled, out_res_r.row, out_res_r.column,
                       out_res_r.cell_attr, out_res_r.cell_char};

  // The engine works on one item at a time: after a beat is taken, the
  // input stays closed for at least the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is still in work");

  // A scroll always leaves the cursor just after the first cell of the last row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |->
      (out_tdata[27:23] == tcw_pkg::row_out_t'(ROWS - 1)) && (out_tdata[22:16] == 7'd1))
    else $error("scroll result with wrong cursor position");

  // A scroll is only reported for a put, which never carries cell contents.
  a_scroll_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[28]) |-> (out_tdata[15:0] == 16'h0000))
    else $error("scroll result carries cell data");

  // The engine never offers a result while a memory write-back is pending.
  a_no_result_mid_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !ram_wr_en)
    else $error("result offered while the screen memory is being written");

endmodule

`default_nettype wire
